@@ rtl/clr_pkg.sv @@
// Package with the shared types and constants of the clipped line rasterizer.
package clr_pkg;

   localparam int unsigned COORD_W = 12;
   localparam int unsigned SIZE_W = 12;
   localparam int unsigned COLOR_W = 24;
   localparam int unsigned CSR_IDX_W = 4;
   localparam int unsigned CSR_DATA_W = 24;
   localparam logic [SIZE_W-1:0] CLIP_SIZE_RESET = 12'd256;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CLIP_LEFT  = 4'd0,
      CSR_CLIP_TOP   = 4'd1,
      CSR_CLIP_SIZE  = 4'd2,
      CSR_DRAW_COLOR = 4'd3
   } csr_index_type;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic done;
   } ctrl_status_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] pixel_x;
      logic signed [COORD_W-1:0] pixel_y;
      logic                      inside_clip;
      logic [COLOR_W-1:0]        pixel_color;
      logic                      last_pixel;
      logic                      rejected;
   } rsp_payload_type;

endpackage

@@ rtl/clr_interfaces.sv @@
// Channel interfaces for line requests, pixel results and register writes.
interface clr_req_if;
   logic                                       valid;
   logic                                       ready;
   logic signed [clr_pkg::COORD_W-1:0]         start_x;
   logic signed [clr_pkg::COORD_W-1:0]         start_y;
   logic signed [clr_pkg::COORD_W-1:0]         end_x;
   logic signed [clr_pkg::COORD_W-1:0]         end_y;

   modport source (output valid, start_x, start_y, end_x, end_y, input ready);
   modport sink (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface clr_rsp_if;
   logic                                       valid;
   logic                                       ready;
   logic signed [clr_pkg::COORD_W-1:0]         pixel_x;
   logic signed [clr_pkg::COORD_W-1:0]         pixel_y;
   logic                                       inside_clip;
   logic [clr_pkg::COLOR_W-1:0]                pixel_color;
   logic                                       last_pixel;
   logic                                       rejected;

   modport source (output valid, pixel_x, pixel_y, inside_clip, pixel_color, last_pixel,
                   rejected, input ready);
   modport sink (input valid, pixel_x, pixel_y, inside_clip, pixel_color, last_pixel,
                 rejected, output ready);
endinterface

interface clr_csr_if;
   logic                                       valid;
   logic                                       ready;
   logic [clr_pkg::CSR_IDX_W-1:0]              index;
   logic [clr_pkg::CSR_DATA_W-1:0]             data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/clr_ctrl.sv @@
// Controller state machine that sequences line loading and pixel emission.
module clr_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  clr_pkg::ctrl_status_type status,
   output clr_pkg::ctrl_cmd_type    cmd
);

   clr_pkg::ctrl_state_type state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         clr_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = clr_pkg::ST_WALK;
            end
         end
         clr_pkg::ST_WALK: begin
            if (slot_free && status.done) begin
               state_in = clr_pkg::ST_IDLE;
            end
         end
         default: state_in = clr_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd.load = 1'b0;
      cmd.emit = 1'b0;
      unique case (state_ff)
         clr_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load = req_valid;
         end
         clr_pkg::ST_WALK: begin
            cmd.emit = slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= clr_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/clr_datapath.sv @@
// Datapath with the clip registers, the Bresenham walker and the result register.
module clr_datapath #(
   parameter int unsigned MAX_SPAN = 63
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write,
   input  logic [clr_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [clr_pkg::CSR_DATA_W-1:0]        csr_data,
   input  logic signed [clr_pkg::COORD_W-1:0]    start_x,
   input  logic signed [clr_pkg::COORD_W-1:0]    start_y,
   input  logic signed [clr_pkg::COORD_W-1:0]    end_x,
   input  logic signed [clr_pkg::COORD_W-1:0]    end_y,
   input  clr_pkg::ctrl_cmd_type                 cmd,
   output clr_pkg::ctrl_status_type              status,
   output clr_pkg::rsp_payload_type              result
);

   localparam int unsigned CW = clr_pkg::COORD_W;
   localparam int unsigned SPAN_W = $clog2(MAX_SPAN + 1);
   localparam int unsigned ERR_W = SPAN_W + 3;
   localparam int unsigned CLIP_W = CW + 2;

   logic signed [CW-1:0]                 clip_left_ff, clip_top_ff;
   logic [clr_pkg::SIZE_W-1:0]           clip_size_ff;
   logic [clr_pkg::COLOR_W-1:0]          draw_color_ff;

   logic signed [CW-1:0]                 walk_x_ff, walk_y_ff;
   logic signed [ERR_W-1:0]              error_term_ff;
   logic [SPAN_W-1:0]                    span_x_ff, span_y_ff;
   logic [1:0]                           step_dirs_ff;
   logic signed [CW-1:0]                 target_x_ff, target_y_ff;
   logic                                 reject_ff;
   clr_pkg::rsp_payload_type             result_ff, result_in;

   logic signed [CW:0]                   diff_x, diff_y;
   logic [CW-1:0]                        abs_x, abs_y;
   logic                                 too_long;
   logic signed [ERR_W-1:0]              span_xs, span_ys;
   logic signed [ERR_W:0]                e2;
   logic                                 step_x, step_y;
   logic signed [ERR_W-1:0]              error_next;
   logic signed [CLIP_W-1:0]             px, py, left, top, right, bottom;
   logic                                 in_window;
   logic                                 done;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_left_ff <= '0;
         clip_top_ff <= '0;
         clip_size_ff <= clr_pkg::CLIP_SIZE_RESET;
         draw_color_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            clr_pkg::CSR_CLIP_LEFT:  clip_left_ff <= csr_data[CW-1:0];
            clr_pkg::CSR_CLIP_TOP:   clip_top_ff <= csr_data[CW-1:0];
            clr_pkg::CSR_CLIP_SIZE:  clip_size_ff <= csr_data[clr_pkg::SIZE_W-1:0];
            clr_pkg::CSR_DRAW_COLOR: draw_color_ff <= csr_data[clr_pkg::COLOR_W-1:0];
            default: ;
         endcase
      end
   end

   assign diff_x = {end_x[CW-1], end_x} - {start_x[CW-1], start_x};
   assign diff_y = {end_y[CW-1], end_y} - {start_y[CW-1], start_y};
   assign abs_x = diff_x[CW] ? CW'(-diff_x) : diff_x[CW-1:0];
   assign abs_y = diff_y[CW] ? CW'(-diff_y) : diff_y[CW-1:0];
   assign too_long = (abs_x > CW'(MAX_SPAN)) || (abs_y > CW'(MAX_SPAN));

   assign span_xs = $signed({{(ERR_W - SPAN_W){1'b0}}, span_x_ff});
   assign span_ys = $signed({{(ERR_W - SPAN_W){1'b0}}, span_y_ff});
   assign e2 = {error_term_ff, 1'b0};
   assign step_x = e2 > -$signed({span_ys[ERR_W-1], span_ys});
   assign step_y = e2 < $signed({span_xs[ERR_W-1], span_xs});

   always_comb begin
      error_next = error_term_ff;
      if (step_x) begin
         error_next = error_next - span_ys;
      end
      if (step_y) begin
         error_next = error_next + span_xs;
      end
   end

   assign px = CLIP_W'(walk_x_ff);
   assign py = CLIP_W'(walk_y_ff);
   assign left = CLIP_W'(clip_left_ff);
   assign top = CLIP_W'(clip_top_ff);
   assign right = left + $signed({2'b00, clip_size_ff});
   assign bottom = top + $signed({2'b00, clip_size_ff});
   assign in_window = (px >= left) && (px < right) && (py >= top) && (py < bottom);

   assign done = reject_ff || ((walk_x_ff == target_x_ff) && (walk_y_ff == target_y_ff));
   assign status.done = done;

   always_comb begin
      result_in = result_ff;
      if (cmd.emit) begin
         result_in.pixel_x = reject_ff ? '0 : walk_x_ff;
         result_in.pixel_y = reject_ff ? '0 : walk_y_ff;
         result_in.inside_clip = !reject_ff && in_window;
         result_in.pixel_color = reject_ff ? '0 : draw_color_ff;
         result_in.last_pixel = done;
         result_in.rejected = reject_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         result_ff <= '0;
         walk_x_ff <= '0;
         walk_y_ff <= '0;
         target_x_ff <= '0;
         target_y_ff <= '0;
         span_x_ff <= '0;
         span_y_ff <= '0;
         error_term_ff <= '0;
         step_dirs_ff <= '0;
         reject_ff <= 1'b0;
      end else begin
         result_ff <= result_in;
         if (cmd.load) begin
            walk_x_ff <= start_x;
            walk_y_ff <= start_y;
            target_x_ff <= end_x;
            target_y_ff <= end_y;
            span_x_ff <= abs_x[SPAN_W-1:0];
            span_y_ff <= abs_y[SPAN_W-1:0];
            error_term_ff <= ERR_W'($signed({1'b0, abs_x[SPAN_W-1:0]}))
                             - ERR_W'($signed({1'b0, abs_y[SPAN_W-1:0]}));
            step_dirs_ff <= {(start_y >= end_y), (start_x >= end_x)};
            reject_ff <= too_long;
         end else if (cmd.emit && !done) begin
            error_term_ff <= error_next;
            if (step_x) begin
               walk_x_ff <= step_dirs_ff[0] ? walk_x_ff - CW'(1) : walk_x_ff + CW'(1);
            end
            if (step_y) begin
               walk_y_ff <= step_dirs_ff[1] ? walk_y_ff - CW'(1) : walk_y_ff + CW'(1);
            end
         end
      end
   end

   assign result = result_ff;

endmodule

@@ rtl/clipped_line_rasterizer.sv @@
// Top level of the clipped line rasterizer: controller, datapath and channel wiring.
//
//   Channel   Direction  Carries
//   req_bus   in         start_x, start_y, end_x, end_y of one line
//   rsp_bus   out        pixel_x, pixel_y, inside_clip, pixel_color, last_pixel, rejected
//   csr_bus   in         register index and write data
//
// A line is first loaded into the walker, then yields one pixel per cycle while the result
// register is free. A rejected line yields one item. There is a single Bresenham walker.
// Reset is synchronous and restores the clip window to 0, 0 with side 256 and colour 0.
// A stalled result register holds the walker; a new line is taken as soon as the last
// pixel of the previous one sits in the result register.
module clipped_line_rasterizer #(
   parameter int unsigned MAX_SPAN = 63
) (
   input logic        clock,
   input logic        reset,
   clr_req_if.sink    req_bus,
   clr_rsp_if.source  rsp_bus,
   clr_csr_if.sink    csr_bus
);

   clr_pkg::ctrl_cmd_type    cmd;
   clr_pkg::ctrl_status_type status;
   clr_pkg::rsp_payload_type result;

   assign csr_bus.ready = 1'b1;

   clr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   clr_datapath #(
      .MAX_SPAN (MAX_SPAN)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_bus.valid),
      .csr_index (csr_bus.index),
      .csr_data  (csr_bus.data),
      .start_x   (req_bus.start_x),
      .start_y   (req_bus.start_y),
      .end_x     (req_bus.end_x),
      .end_y     (req_bus.end_y),
      .cmd       (cmd),
      .status    (status),
      .result    (result)
   );

   assign rsp_bus.pixel_x = result.pixel_x;
   assign rsp_bus.pixel_y = result.pixel_y;
   assign rsp_bus.inside_clip = result.inside_clip;
   assign rsp_bus.pixel_color = result.pixel_color;
   assign rsp_bus.last_pixel = result.last_pixel;
   assign rsp_bus.rejected = result.rejected;

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench for the clipped line rasterizer, checking every pixel item of each line.
module tb_top;

   localparam int MAX_SPAN = 63;
   localparam int ITEMS_PER_PHASE = 23;
   localparam int PHASE_COUNT = 9;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES = 20;
   localparam int HOLD_CYCLES = 400;
   localparam int LIMIT_CYCLES = 1000000;
   localparam int COORD_MIN = -2048;
   localparam int COORD_MAX = 2047;

   typedef struct packed {
      logic signed [clr_pkg::COORD_W-1:0] start_x;
      logic signed [clr_pkg::COORD_W-1:0] start_y;
      logic signed [clr_pkg::COORD_W-1:0] end_x;
      logic signed [clr_pkg::COORD_W-1:0] end_y;
   } line_request_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   line_request_type line_backlog[$];
   clr_pkg::rsp_payload_type expected_pixels[$];

   line_request_type line_out = '0;
   logic line_valid = 1'b0;
   int line_gap = 0;
   int line_calm = 0;
   int lines_accepted = 0;

   logic pixel_ready = 1'b0;
   logic pixel_hold = 1'b0;
   int pixel_gap = 0;
   int pixel_calm = 0;
   int mismatch_count = 0;
   int hold_at = 0;

   logic reg_valid = 1'b0;
   logic [clr_pkg::CSR_IDX_W-1:0] reg_index = '0;
   logic [clr_pkg::CSR_DATA_W-1:0] reg_data = '0;

   int win_left = 0;
   int win_top = 0;
   int win_size = int'(clr_pkg::CLIP_SIZE_RESET);
   logic [clr_pkg::COLOR_W-1:0] pen_color = '0;

   int cycle_count = 0;

   clr_req_if req_bus();
   clr_rsp_if rsp_bus();
   clr_csr_if csr_bus();

   assign req_bus.valid = line_valid;
   assign req_bus.start_x = line_out.start_x;
   assign req_bus.start_y = line_out.start_y;
   assign req_bus.end_x = line_out.end_x;
   assign req_bus.end_y = line_out.end_y;
   assign rsp_bus.ready = pixel_ready;
   assign csr_bus.valid = reg_valid;
   assign csr_bus.index = reg_index;
   assign csr_bus.data = reg_data;

   clipped_line_rasterizer #(
      .MAX_SPAN(MAX_SPAN)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus),
      .csr_bus(csr_bus)
   );

   initial forever #5 clock = ~clock;

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic void rasterize_line(input line_request_type ln);
      int x0, y0, x1, y1, dx, dy, err, e2, stx, sty, x, y, count;
      clr_pkg::rsp_payload_type px;
      x0 = ln.start_x;
      y0 = ln.start_y;
      x1 = ln.end_x;
      y1 = ln.end_y;
      dx = (x1 >= x0) ? x1 - x0 : x0 - x1;
      dy = (y1 >= y0) ? y1 - y0 : y0 - y1;
      px = '0;
      if (dx > MAX_SPAN || dy > MAX_SPAN) begin
         px.last_pixel = 1'b1;
         px.rejected = 1'b1;
         expected_pixels.push_back(px);
         return;
      end
      stx = (x0 < x1) ? 1 : -1;
      sty = (y0 < y1) ? 1 : -1;
      err = dx - dy;
      x = x0;
      y = y0;
      for (count = 0; count <= MAX_SPAN; count++) begin
         px.pixel_x = x[clr_pkg::COORD_W-1:0];
         px.pixel_y = y[clr_pkg::COORD_W-1:0];
         px.inside_clip = (x >= win_left) && (x < win_left + win_size) &&
                          (y >= win_top) && (y < win_top + win_size);
         px.pixel_color = pen_color;
         px.last_pixel = (x == x1) && (y == y1);
         px.rejected = 1'b0;
         expected_pixels.push_back(px);
         if (px.last_pixel) break;
         e2 = 2 * err;
         if (e2 > -dy) begin
            err -= dy;
            x += stx;
         end
         if (e2 < dx) begin
            err += dx;
            y += sty;
         end
      end
   endfunction

   function automatic logic signed [clr_pkg::COORD_W-1:0] clamp_coord(input int v);
      int c;
      c = (v < COORD_MIN) ? COORD_MIN : (v > COORD_MAX) ? COORD_MAX : v;
      return c[clr_pkg::COORD_W-1:0];
   endfunction

   task automatic add_line(input int sx, input int sy, input int ex, input int ey);
      line_request_type ln;
      ln.start_x = clamp_coord(sx);
      ln.start_y = clamp_coord(sy);
      ln.end_x = clamp_coord(ex);
      ln.end_y = clamp_coord(ey);
      line_backlog.push_back(ln);
   endtask

   task automatic write_register(input logic [clr_pkg::CSR_IDX_W-1:0] idx,
                                 input logic [clr_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      reg_valid <= 1'b1;
      reg_index <= idx;
      reg_data <= value;
      do @(posedge clock); while (!csr_bus.ready);
      reg_valid <= 1'b0;
      case (idx)
         clr_pkg::CSR_CLIP_LEFT: win_left = int'($signed(value[clr_pkg::COORD_W-1:0]));
         clr_pkg::CSR_CLIP_TOP: win_top = int'($signed(value[clr_pkg::COORD_W-1:0]));
         clr_pkg::CSR_CLIP_SIZE: win_size = int'(value[clr_pkg::SIZE_W-1:0]);
         clr_pkg::CSR_DRAW_COLOR: pen_color = value[clr_pkg::COLOR_W-1:0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (line_backlog.size() != 0 || line_valid || expected_pixels.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      logic offer;
      if (reset) begin
         line_valid <= 1'b0;
         line_gap = 0;
      end else begin
         offer = line_valid;
         if (offer && req_bus.ready) begin
            rasterize_line(line_out);
            lines_accepted++;
            offer = 1'b0;
            if (line_calm > 0) begin
               line_calm--;
               line_gap = 0;
            end else if ($urandom_range(0, 19) == 0) begin
               line_calm = $urandom_range(10, 40);
               line_gap = 0;
            end else begin
               line_gap = $urandom_range(0, 12);
            end
         end
         if (!offer) begin
            if (line_gap > 0) begin
               line_gap--;
            end else if (line_backlog.size() > 0) begin
               line_out <= line_backlog.pop_front();
               offer = 1'b1;
            end
         end
         line_valid <= offer;
      end
   end

   always @(posedge clock) begin
      clr_pkg::rsp_payload_type got, want;
      logic take;
      if (reset) begin
         pixel_ready <= 1'b0;
         pixel_gap = 0;
      end else begin
         take = pixel_ready;
         if (rsp_bus.valid && pixel_ready) begin
            got.pixel_x = rsp_bus.pixel_x;
            got.pixel_y = rsp_bus.pixel_y;
            got.inside_clip = rsp_bus.inside_clip;
            got.pixel_color = rsp_bus.pixel_color;
            got.last_pixel = rsp_bus.last_pixel;
            got.rejected = rsp_bus.rejected;
            if (expected_pixels.size() == 0) begin
               if (mismatch_count < 10)
                  $display("Unexpected item: x=%0d y=%0d in=%0b col=%06h last=%0b rej=%0b",
                           got.pixel_x, got.pixel_y, got.inside_clip, got.pixel_color,
                           got.last_pixel, got.rejected);
               mismatch_count++;
            end else begin
               want = expected_pixels.pop_front();
               if (got.pixel_x !== want.pixel_x || got.pixel_y !== want.pixel_y ||
                   got.inside_clip !== want.inside_clip ||
                   got.pixel_color !== want.pixel_color ||
                   got.last_pixel !== want.last_pixel || got.rejected !== want.rejected) begin
                  if (mismatch_count < 10) begin
                     $display("Expected: x=%0d y=%0d in=%0b col=%06h last=%0b rej=%0b",
                              want.pixel_x, want.pixel_y, want.inside_clip, want.pixel_color,
                              want.last_pixel, want.rejected);
                     $display("Actual:   x=%0d y=%0d in=%0b col=%06h last=%0b rej=%0b",
                              got.pixel_x, got.pixel_y, got.inside_clip, got.pixel_color,
                              got.last_pixel, got.rejected);
                  end
                  mismatch_count++;
               end
            end
            take = 1'b0;
            if (pixel_calm > 0) begin
               pixel_calm--;
               pixel_gap = 0;
            end else if ($urandom_range(0, 19) == 0) begin
               pixel_calm = $urandom_range(10, 60);
               pixel_gap = 0;
            end else begin
               pixel_gap = $urandom_range(0, 12);
            end
         end
         if (!take) begin
            if (pixel_gap > 0) pixel_gap--;
            else take = 1'b1;
         end
         if (pixel_hold) take = 1'b0;
         pixel_ready <= take;
      end
   end

   // The receiver stops for a long stretch while the sender keeps offering lines.
   initial begin
      do @(negedge clock); while (hold_at == 0 || lines_accepted < hold_at);
      @(posedge clock);
      pixel_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      pixel_hold <= 1'b0;
   end

   initial begin : stimulus
      int phase, n, kind, l, t, s, ax, ay, sx, sy, ex, ey;
      logic [clr_pkg::COLOR_W-1:0] c;
      logic [clr_pkg::CSR_IDX_W-1:0] spare_idx;
      do @(negedge clock); while (reset);
      @(negedge clock);
      add_line(5, 5, 5, 5);
      add_line(0, 0, 10, 0);
      add_line(10, 3, 0, 3);
      add_line(3, 0, 3, 10);
      add_line(3, 10, 3, 0);
      add_line(0, 0, 7, 7);
      add_line(7, 7, 0, 0);
      add_line(-5, 2, 4, -1);
      add_line(250, 250, 260, 270);
      add_line(-2048, -2048, -1985, -1985);
      add_line(2047, 2047, 1984, 1984);
      add_line(2047, -2048, 1984, -1985);
      add_line(-2048, 2047, -1985, 1984);
      add_line(0, 0, 64, 0);
      add_line(0, 0, 0, -64);
      add_line(-2048, -2048, 2047, 2047);
      add_line(2047, 0, -2048, 0);
      add_line(100, 100, 163, 101);
      add_line(100, 100, 99, 37);
      add_line(255, 255, 256, 256);
      add_line(-1, -1, 0, 0);
      add_line(1, 60, 62, -3);
      wait_drained();

      for (phase = 1; phase <= PHASE_COUNT; phase++) begin
         c = clr_pkg::COLOR_W'($urandom);
         case (phase)
            1: begin
               l = COORD_MIN;
               t = COORD_MIN;
               s = 2048;
               c = '1;
            end
            2: begin
               l = COORD_MAX;
               t = COORD_MAX;
               s = 1;
            end
            3: begin
               l = int'($urandom_range(0, 200)) - 100;
               t = int'($urandom_range(0, 200)) - 100;
               s = 0;
            end
            4: begin
               l = COORD_MIN;
               t = 0;
               s = 4095;
               c = '0;
            end
            5: begin
               l = int'($urandom_range(0, 120)) - 60;
               t = int'($urandom_range(0, 120)) - 60;
               s = $urandom_range(1, 120);
            end
            default: begin
               l = int'($urandom_range(0, 4095)) + COORD_MIN;
               t = int'($urandom_range(0, 4095)) + COORD_MIN;
               s = $urandom_range(1, 300);
            end
         endcase
         write_register(clr_pkg::CSR_CLIP_LEFT,
                        clr_pkg::CSR_DATA_W'(l[clr_pkg::COORD_W-1:0]));
         write_register(clr_pkg::CSR_CLIP_TOP,
                        clr_pkg::CSR_DATA_W'(t[clr_pkg::COORD_W-1:0]));
         write_register(clr_pkg::CSR_CLIP_SIZE,
                        clr_pkg::CSR_DATA_W'(s[clr_pkg::SIZE_W-1:0]));
         write_register(clr_pkg::CSR_DRAW_COLOR, clr_pkg::CSR_DATA_W'(c));
         if (phase == 5) begin
            spare_idx = clr_pkg::CSR_IDX_W'($urandom_range(
                           int'(clr_pkg::CSR_DRAW_COLOR) + 1,
                           (1 << clr_pkg::CSR_IDX_W) - 1));
            write_register(spare_idx, clr_pkg::CSR_DATA_W'($urandom));
            hold_at = lines_accepted + 3;
         end
         @(negedge clock);
         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            kind = $urandom_range(0, 15);
            ax = (($urandom_range(0, 1) != 0) ? win_left : win_left + win_size) +
                 int'($urandom_range(0, 40)) - 20;
            ay = (($urandom_range(0, 1) != 0) ? win_top : win_top + win_size) +
                 int'($urandom_range(0, 40)) - 20;
            sx = ax;
            sy = ay;
            ex = sx + int'($urandom_range(0, 126)) - MAX_SPAN;
            ey = sy + int'($urandom_range(0, 126)) - MAX_SPAN;
            case (kind)
               0: begin
                  sx = int'($urandom_range(0, 4095)) + COORD_MIN;
                  sy = int'($urandom_range(0, 4095)) + COORD_MIN;
                  ex = int'($urandom_range(0, 4095)) + COORD_MIN;
                  ey = int'($urandom_range(0, 4095)) + COORD_MIN;
               end
               1: ex = sx + (($urandom_range(0, 1) != 0) ? 1 : -1) *
                       (MAX_SPAN + 1 + int'($urandom_range(0, 20)));
               2: begin
                  ex = sx;
                  ey = sy;
               end
               3: ex = sx + (($urandom_range(0, 1) != 0) ? MAX_SPAN : -MAX_SPAN);
               4: ey = sy + (($urandom_range(0, 1) != 0) ? MAX_SPAN : -MAX_SPAN);
               default: ;
            endcase
            add_line(sx, sy, ex, ey);
         end
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_pixels.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/clr_pkg.sv
rtl/clr_interfaces.sv
rtl/clr_ctrl.sv
rtl/clr_datapath.sv
rtl/clipped_line_rasterizer.sv
verif/tb_top.sv
